FILE: rtl/mec_pkg.sv
// Package for the escape-time counter: job type, engine states, defaults and
// the saturating fixed-point helpers. No dependencies.
`timescale 1ns / 1ps

package mec_pkg;

  localparam int ITERATION_LIMIT_DEF = 100;
  localparam int GROUP_LANES_DEF     = 8;
  localparam int QUEUE_DEPTH         = 2;
  localparam int FRAC_BITS           = 25;
  localparam int ITER_W              = 8;

  localparam logic signed [31:0] COLUMN_STEP_RESET = 32'sd209715;
  localparam logic signed [31:0] FIX_FOUR          = 32'sd134217728;
  localparam logic signed [39:0] S32_MAX           = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN           = -40'sd2147483648;

  // One point on its way from the front to the iteration engine.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_MULT
  } bk_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [39:0] s;
    s = 40'(a) + 40'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [39:0] s;
    s = 40'(a) - 40'(b);
    return sat32(s);
  endfunction

  // The arithmetic shift floors, which matches rounding toward minus infinity.
  function automatic logic signed [31:0] fix_scale(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p >>> FRAC_BITS;
    return sat32(q[39:0]);
  endfunction

endpackage

FILE: rtl/mec_front.sv
// Front of the escape-time counter: takes points, holds the column step and
// forms the real coordinate. Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_front #(
  parameter int GROUP_LANES = mec_pkg::GROUP_LANES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] real_start,
  input  logic [2:0]         lane_index,
  input  logic signed [31:0] imag_coord,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] column_step,
  output logic               q_push,
  output mec_pkg::job_t      q_data,
  input  logic               q_full
);

  localparam int LaneMax = (GROUP_LANES > 8) ? 7 : GROUP_LANES - 1;

  logic signed [31:0] step;
  logic               stage_valid;
  logic signed [31:0] stage_start;
  logic [2:0]         stage_lane;
  logic signed [31:0] stage_cy;
  logic [2:0]         lane_clamped;
  logic signed [35:0] offset_full;
  logic signed [31:0] offset;

  assign cfg_ready = 1'b1;
  assign full      = stage_valid && q_full;
  assign q_push    = stage_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mec_pkg::COLUMN_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step <= column_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (push && !full) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      stage_start <= real_start;
      stage_lane  <= lane_index;
      stage_cy    <= imag_coord;
    end
  end

  // Lanes beyond the group are clamped to its last lane.
  always_comb begin
    lane_clamped = (stage_lane > 3'(LaneMax)) ? 3'(LaneMax) : stage_lane;
    offset_full  = 36'(signed'({1'b0, lane_clamped})) * 36'(step);
    offset       = mec_pkg::sat32(40'(offset_full));
    q_data.cx    = mec_pkg::sat_add(stage_start, offset);
    q_data.cy    = stage_cy;
  end

endmodule

FILE: rtl/mec_queue.sv
// Short queue of jobs between the front and the iteration engine.
// Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mec_pkg::job_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output mec_pkg::job_t rd_data,
  output logic          q_empty
);

  localparam int Depth = mec_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  mec_pkg::job_t   slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == CntW'(Depth));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/mec_back.sv
// Iteration engine: runs z = z^2 + c on one job at a time with a shared set
// of three multipliers and holds the result until it is taken. Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_back #(
  parameter int ITERATION_LIMIT = mec_pkg::ITERATION_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  mec_pkg::job_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [3:0]    escape_count
);

  localparam int IterW = mec_pkg::ITER_W;

  mec_pkg::bk_state_t state;
  mec_pkg::bk_state_t state_next;

  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [63:0] p_xx;
  logic signed [63:0] p_yy;
  logic signed [63:0] p_xy;
  logic [IterW-1:0]   iter;
  logic               res_valid;
  logic [3:0]         result;

  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [31:0] m_xy;
  logic signed [31:0] x_next;
  logic signed [31:0] y_next;
  logic               escaped;
  logic               at_limit;
  logic               start;
  logic               finish;

  assign empty        = !res_valid;
  assign escape_count = result;

  always_comb begin
    sq_x     = mec_pkg::fix_scale(p_xx);
    sq_y     = mec_pkg::fix_scale(p_yy);
    m_xy     = mec_pkg::fix_scale(p_xy);
    // The squares belong to the last update, so there is nothing to test before it.
    escaped  = (iter != '0) &&
               (mec_pkg::sat_add(sq_x, sq_y) > mec_pkg::FIX_FOUR);
    at_limit = (iter == IterW'(ITERATION_LIMIT));
    x_next   = mec_pkg::sat_add(mec_pkg::sat_sub(sq_x, sq_y), cx);
    y_next   = mec_pkg::sat_add(mec_pkg::sat_add(m_xy, m_xy), cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mec_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    finish     = 1'b0;
    case (state)
      mec_pkg::BK_IDLE: begin
        if (!q_empty && !res_valid) begin
          start      = 1'b1;
          state_next = mec_pkg::BK_UPDATE;
        end
      end
      mec_pkg::BK_UPDATE: begin
        if (escaped || at_limit) begin
          finish     = 1'b1;
          state_next = mec_pkg::BK_IDLE;
        end else begin
          state_next = mec_pkg::BK_MULT;
        end
      end
      mec_pkg::BK_MULT: begin
        state_next = mec_pkg::BK_UPDATE;
      end
      default: begin
        state_next = mec_pkg::BK_IDLE;
      end
    endcase
  end

  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (pop && res_valid) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx   <= q_data.cx;
      cy   <= q_data.cy;
      x    <= '0;
      y    <= '0;
      p_xx <= '0;
      p_yy <= '0;
      p_xy <= '0;
      iter <= '0;
    end else if (state == mec_pkg::BK_UPDATE && !finish) begin
      x    <= x_next;
      y    <= y_next;
      iter <= iter + 1'b1;
    end else if (state == mec_pkg::BK_MULT) begin
      p_xx <= x * x;
      p_yy <= y * y;
      p_xy <= x * y;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (escaped) begin
        result <= 4'(iter - 1'b1);
      end else begin
        result <= iter[3:0];
      end
    end
  end

endmodule

FILE: rtl/mandelbrot_escape_counter.sv
// Escape-time counter: one point in, one 4-bit count out per transaction.
// A point that runs n iterations (n up to ITERATION_LIMIT) stays in the iteration
// engine's update/multiply loop around the shared multipliers for those iterations;
// a new point starts only once the engine is idle and the previous result has been
// taken. Reset is synchronous: it empties the pipeline and queue and loads the
// column step with 209715.
`timescale 1ns / 1ps

module mandelbrot_escape_counter #(
  parameter int ITERATION_LIMIT = mec_pkg::ITERATION_LIMIT_DEF,
  parameter int GROUP_LANES     = mec_pkg::GROUP_LANES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] real_start,
  input  logic [2:0]         lane_index,
  input  logic signed [31:0] imag_coord,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         escape_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] column_step
);

  logic          wr_en;
  mec_pkg::job_t wr_data;
  logic          q_full;
  logic          rd_en;
  mec_pkg::job_t rd_data;
  logic          q_empty;

  mec_front #(
    .GROUP_LANES(GROUP_LANES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .real_start  (real_start),
    .lane_index  (lane_index),
    .imag_coord  (imag_coord),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .column_step (column_step),
    .q_push      (wr_en),
    .q_data      (wr_data),
    .q_full      (q_full)
  );

  mec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .q_full  (q_full),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .q_empty (q_empty)
  );

  mec_back #(
    .ITERATION_LIMIT(ITERATION_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (rd_data),
    .q_pop        (rd_en),
    .empty        (empty),
    .pop          (pop),
    .escape_count (escape_count)
  );

endmodule
